>>> hdl/dosf_pkg.sv
// dosf_pkg: shared constants and types of the drop-oldest sample fifo
// no dependencies; imported by every module of the block except dosf_ram
package dosf_pkg;

    // sample store geometry
    localparam int FIFO_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(FIFO_DEPTH);
    localparam int PTR_W      = $clog2(2 * FIFO_DEPTH);

    // word field widths
    localparam int WORD_W  = 32;
    localparam int FILL_W  = 11;
    localparam int COUNT_W = 32;

    // result bus packing, zero-filled to whole bytes
    localparam int M_FIELDS_W = WORD_W + 2 + FILL_W + 4 * COUNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    // operation codes carried on tuser
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    // classified word handed from front to back
    typedef struct packed {
        logic [WORD_W-1:0] word;
        op_t               op;
        logic              last;
        logic              dropped;
        logic              starved;
        logic [FILL_W-1:0] fill;
    } q_entry_t;

endpackage

>>> hdl/dosf_ram.sv
// dosf_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module dosf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/dosf_front.sv
// dosf_front: accepts words, keeps the fifo pointers, classifies drop/starve
// depends on dosf_pkg and dosf_ram (sample store)
module dosf_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  dosf_pkg::op_t            in_op,
    input  logic [dosf_pkg::WORD_W-1:0] in_word,
    input  logic                     in_last,
    output logic                     out_valid,
    output dosf_pkg::q_entry_t       out_entry
);
    import dosf_pkg::*;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic             stage_valid_reg;
    q_entry_t         stage_reg, stage_next;
    logic             take;
    logic [PTR_W:0]   fill_cur;
    logic [PTR_W:0]   fill_after;
    logic             full, empty;
    logic             ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(2 * FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] s;
        s = (p >= PTR_W'(FIFO_DEPTH)) ? p - PTR_W'(FIFO_DEPTH) : p;
        return s[ADDR_W-1:0];
    endfunction

    assign take = in_valid && in_ready;

    // current occupancy from the two pointers
    always_comb begin
        if (wp_reg >= rp_reg) begin
            fill_cur = {1'b0, wp_reg} - {1'b0, rp_reg};
        end else begin
            fill_cur = {1'b0, wp_reg} + (PTR_W+1)'(2 * FIFO_DEPTH) - {1'b0, rp_reg};
        end
        full  = fill_cur >= (PTR_W+1)'(FIFO_DEPTH);
        empty = fill_cur == '0;
    end

    // classify the word and move the pointers
    always_comb begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = ptr_slot(wp_reg);
        ram_raddr  = ptr_slot(rp_reg);
        fill_after = fill_cur;
        stage_next = stage_reg;
        if (take) begin
            stage_next.word    = '0;
            stage_next.op      = in_op;
            stage_next.last    = in_last;
            stage_next.dropped = 1'b0;
            stage_next.starved = 1'b0;
            case (in_op)
                OP_PUSH: begin
                    ram_we  = 1'b1;
                    wp_next = ptr_inc(wp_reg);
                    if (full) begin
                        rp_next            = ptr_inc(rp_reg);
                        stage_next.dropped = 1'b1;
                        fill_after         = (PTR_W+1)'(FIFO_DEPTH);
                    end else begin
                        fill_after = fill_cur + 1'b1;
                    end
                end
                OP_POP: begin
                    if (empty) begin
                        stage_next.starved = 1'b1;
                        fill_after         = '0;
                    end else begin
                        ram_re     = 1'b1;
                        rp_next    = ptr_inc(rp_reg);
                        fill_after = fill_cur - 1'b1;
                    end
                end
                default: begin
                    stage_next.starved = 1'b0;
                end
            endcase
            stage_next.fill = FILL_W'(fill_after);
        end
    end

    // pointer and stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg          <= '0;
            rp_reg          <= '0;
            stage_valid_reg <= 1'b0;
        end else begin
            wp_reg          <= wp_next;
            rp_reg          <= rp_next;
            stage_valid_reg <= take;
        end
        stage_reg <= stage_next;
    end

    dosf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_word),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // popped word arrives from the registered store read in the same cycle as the staged entry
    always_comb begin
        out_entry = stage_reg;
        if (stage_reg.op == OP_POP && !stage_reg.starved) begin
            out_entry.word = ram_rdata;
        end else begin
            out_entry.word = '0;
        end
    end

    assign out_valid = stage_valid_reg;

endmodule

>>> hdl/dosf_queue.sv
// dosf_queue: short queue of classified words between front and back
// depends on dosf_pkg
module dosf_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_valid,
    input  dosf_pkg::q_entry_t wr_entry,
    input  logic               rd_take,
    output logic               rd_valid,
    output dosf_pkg::q_entry_t rd_entry,
    output logic               room
);
    import dosf_pkg::*;

    q_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QA_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QC_W-1:0] count_reg;

    function automatic logic [QA_W-1:0] qptr_inc(input logic [QA_W-1:0] p);
        return (p == QA_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // room for one more word plus the one in flight in the front stage
    assign room     = count_reg <= QC_W'(QUEUE_DEPTH - 2);
    assign rd_valid = count_reg != '0;
    assign rd_entry = slot_reg[rd_ptr_reg];

    // queue pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_valid) begin
                wr_ptr_reg <= qptr_inc(wr_ptr_reg);
            end
            if (rd_take) begin
                rd_ptr_reg <= qptr_inc(rd_ptr_reg);
            end
            if (wr_valid && !rd_take) begin
                count_reg <= count_reg + 1'b1;
            end else if (!wr_valid && rd_take) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (wr_valid) begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

>>> hdl/dosf_back.sv
// dosf_back: chunk and frame counters, result register toward the master side
// depends on dosf_pkg
module dosf_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  dosf_pkg::q_entry_t               q_entry,
    output logic                             q_take,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [dosf_pkg::M_TDATA_W-1:0]   m_data
);
    import dosf_pkg::*;

    logic [COUNT_W-1:0] push_pend_reg, push_pend_next;
    logic [COUNT_W-1:0] drop_pend_reg, drop_pend_next;
    logic [COUNT_W-1:0] pop_pend_reg, pop_pend_next;
    logic [COUNT_W-1:0] starve_pend_reg, starve_pend_next;
    logic [COUNT_W-1:0] captured_reg, captured_next;
    logic [COUNT_W-1:0] played_reg, played_next;
    logic [COUNT_W-1:0] dropped_reg, dropped_next;
    logic [COUNT_W-1:0] starved_reg, starved_next;
    logic               m_valid_reg;
    q_entry_t           res_reg;

    assign q_take = q_valid && (!m_valid_reg || m_ready);

    // per-chunk word counts, halved into the frame counters at chunk end
    always_comb begin
        push_pend_next   = push_pend_reg;
        drop_pend_next   = drop_pend_reg;
        pop_pend_next    = pop_pend_reg;
        starve_pend_next = starve_pend_reg;
        captured_next    = captured_reg;
        played_next      = played_reg;
        dropped_next     = dropped_reg;
        starved_next     = starved_reg;
        case (q_entry.op)
            OP_PUSH: begin
                push_pend_next = push_pend_reg + 1'b1;
                drop_pend_next = drop_pend_reg + COUNT_W'(q_entry.dropped);
                if (q_entry.last) begin
                    captured_next  = captured_reg + (push_pend_next >> 1);
                    dropped_next   = dropped_reg + (drop_pend_next >> 1);
                    push_pend_next = '0;
                    drop_pend_next = '0;
                end
            end
            OP_POP: begin
                pop_pend_next    = pop_pend_reg + 1'b1;
                starve_pend_next = starve_pend_reg + COUNT_W'(q_entry.starved);
                if (q_entry.last) begin
                    played_next      = played_reg + (pop_pend_next >> 1);
                    starved_next     = starved_reg + (starve_pend_next >> 1);
                    pop_pend_next    = '0;
                    starve_pend_next = '0;
                end
            end
            default: begin
                push_pend_next = push_pend_reg;
            end
        endcase
    end

    // counters and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            push_pend_reg   <= '0;
            drop_pend_reg   <= '0;
            pop_pend_reg    <= '0;
            starve_pend_reg <= '0;
            captured_reg    <= '0;
            played_reg      <= '0;
            dropped_reg     <= '0;
            starved_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (q_take) begin
                push_pend_reg   <= push_pend_next;
                drop_pend_reg   <= drop_pend_next;
                pop_pend_reg    <= pop_pend_next;
                starve_pend_reg <= starve_pend_next;
                captured_reg    <= captured_next;
                played_reg      <= played_next;
                dropped_reg     <= dropped_next;
                starved_reg     <= starved_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (q_take) begin
            res_reg <= q_entry;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = M_TDATA_W'({starved_reg, dropped_reg, played_reg, captured_reg,
                                 res_reg.fill, res_reg.starved, res_reg.dropped,
                                 res_reg.word});

endmodule

>>> hdl/drop_oldest_sample_fifo.sv
// drop_oldest_sample_fifo: top level of the drop-oldest monitor sample fifo
// depends on dosf_pkg, dosf_front, dosf_queue, dosf_back
//
// Monitor sample fifo of FIFO_DEPTH 32-bit words between capture and playback.
// Each slave word is a push (tuser 0) or a pop (tuser 1); tlast marks the end
// of a chunk in that direction. A push into a full fifo drops the oldest word,
// a pop from an empty fifo returns zero and flags starved. Every word gives
// one result word carrying the popped word, the flags, the fill level and the
// four wrapping frame counters (halved chunk word counts). One word per clock
// is taken while tready is high and one result per clock leaves while
// m_axis_tready is high; a result passes the front stage and registered store
// read at its accept edge, then a queue slot, then the result register.
// While the master side stalls, tready drops once three words wait in the
// four-entry queue, the fourth entry taking the word still in the front stage.
module drop_oldest_sample_fifo (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [dosf_pkg::WORD_W-1:0]      s_axis_tdata,  // sample_word[31:0]
    input  logic                             s_axis_tuser,  // op[0]
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_word[31:0], dropped[32], starved[33], fill_level[44:34],
    // frames_captured[76:45], frames_played[108:77], frames_dropped[140:109],
    // frames_starved[172:141], zero fill above
    output logic [dosf_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import dosf_pkg::*;

    logic     front_valid;
    q_entry_t front_entry;
    logic     q_valid, q_take, q_room;
    q_entry_t q_entry;

    assign s_axis_tready = q_room;

    // front: pointers, store access, drop/starve classification
    dosf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (q_room),
        .in_op     (op_t'(s_axis_tuser)),
        .in_word   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (front_valid),
        .out_entry (front_entry)
    );

    // decoupling queue
    dosf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_entry (front_entry),
        .rd_take  (q_take),
        .rd_valid (q_valid),
        .rd_entry (q_entry),
        .room     (q_room)
    );

    // back: counters and result register
    dosf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_take  (q_take),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata)
    );

endmodule
